>>> rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Types, constants and helpers shared by the bank mapper and its modulo unit.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int PRG_BANK_BYTES = 16384;
    localparam int SLOT_BYTES     = PRG_BANK_BYTES / 2;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int OFF_W    = 19;
    localparam int CNT_W    = 7;
    localparam int BANK_W   = 6;
    localparam int CHR_W    = 8;
    localparam int RAM_AW   = $clog2(WORK_RAM_BYTES);
    localparam int SLOT_AW  = $clog2(SLOT_BYTES);

    // restoring remainder: steps for a 6-bit dividend and divisor >= 2
    localparam int MOD_STEPS = BANK_W - 1;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam int SHW       = BANK_W + MOD_STEPS;

    localparam logic [CNT_W-1:0] CNT_MIN   = 7'd2;
    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd64;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd32;

    localparam logic [2:0] TGT_PRG_A = 3'd6;
    localparam logic [2:0] TGT_PRG_B = 3'd7;

    typedef enum logic [1:0] {
        OP_CPU_RD = 2'd0,
        OP_CPU_WR = 2'd1,
        OP_PPU_RD = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RG_RAM      = 3'd3,
        RG_BANK     = 3'd4,
        RG_MIRROR   = 3'd5,
        RG_IRQ_LOAD = 3'd6,
        RG_IRQ_EN   = 3'd7
    } t_region;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD
    } t_state;

    typedef struct packed {
        logic              go;
        logic [BANK_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [BANK_W-1:0] remainder;
    } t_mod_rsp;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c < CNT_MIN) r = CNT_MIN;
        if (c > CNT_MAX) r = CNT_MAX;
        return r;
    endfunction

endpackage

>>> rtl/bmsi_mod_unit.sv
// ----------------------------------------------------------------------------
// bmsi_mod_unit
// Iterative remainder of a 6-bit bank number by the bank count: one shared
// compare-and-subtract per cycle, shifted divisor walking down to bit 0.
// ----------------------------------------------------------------------------
module bmsi_mod_unit
    import bmsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic              r_run;
    logic [STEP_W-1:0] r_k;
    logic [BANK_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [SHW-1:0]    shifted;
    logic              ge;
    logic [BANK_W-1:0] n_rem;

    always_comb begin
        shifted = {{(SHW-CNT_W){1'b0}}, r_div} << r_k;
        ge      = {{(SHW-BANK_W){1'b0}}, r_rem} >= shifted;
        n_rem   = ge ? (r_rem - shifted[BANK_W-1:0]) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_req.go) begin
            r_run <= 1'b1;
        end else if (r_run && r_k == '0) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= i_req.dividend;
            r_div <= i_req.divisor;
            r_k   <= STEP_W'(MOD_STEPS - 1);
        end else if (r_run) begin
            r_rem <= n_rem;
            r_k   <= r_k - 1'b1;
        end
    end

    assign o_rsp.done      = r_run && (r_k == '0);
    assign o_rsp.remainder = n_rem;

endmodule

>>> rtl/bank_mapper_with_scanline_irq_top.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_top
// Cartridge bank mapper: CPU/PPU address translation, 8 KB work RAM and a
// reloadable scanline interrupt counter.
// ----------------------------------------------------------------------------
//  channel   handshake               word
//  in        start && !busy          i_op, i_address, i_write_data,
//                                    i_nametable_fetch
//  out       o_done (1-cycle strobe) o_mapped_offset, o_read_data, o_ram_hit,
//                                    o_irq_out
//  cfg       i_cfg_we                i_cfg_wdata (bank count)
//
//  busy is high during execute; a bank data write to a program slot also holds
//  it high while the shared modulo unit runs.
//  o_done pulses in the first cycle that busy is low; a new word may start then.
//  Reset is synchronous; no clearing pass, work RAM is unspecified until written.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq_top
    import bmsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_nametable_fetch,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [OFF_W-1:0]  o_mapped_offset,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_ram_hit,
    output logic              o_irq_out
);

    t_state r_state, n_state;

    // latched word
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic              r_nt;

    // mapper state
    logic [CNT_W-1:0]  r_cnt;
    logic [BANK_W-1:0] r_prg [4];
    logic [CHR_W-1:0]  r_chr [8];
    logic [2:0]        r_target;
    logic              r_prg_swap;
    logic              r_chr_inv;
    logic              r_mirror_h;
    logic [7:0]        r_irq_reload;
    logic [7:0]        r_irq_count;
    logic              r_reload_pend;
    logic              r_irq_enabled;
    logic              r_irq_level;
    logic              r_irq_guard;
    logic [1:0]        r_mod_slot;

    // work RAM
    logic [DATA_W-1:0] r_ram [WORK_RAM_BYTES];
    logic [DATA_W-1:0] r_ram_q;

    // result registers
    logic              r_done;
    logic [OFF_W-1:0]  r_out_off;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_hit;
    logic              r_out_irq;

    logic              accept;
    logic              exec_en;
    logic              mod_go;
    logic              mod_fin;
    t_mod_req          mod_req;
    t_mod_rsp          mod_rsp;

    logic              is_ram;
    logic              is_wr;
    t_region           region;
    logic              prg_data_wr;
    logic [OFF_W-1:0]  x_off;
    logic [DATA_W-1:0] x_rd;
    logic              x_hit;
    logic [7:0]        n_irq_count;
    logic              n_irq_level;
    logic              n_irq_guard;
    logic              n_reload_pend;
    logic              n_irq_enabled;
    logic [CNT_W-1:0]  cfg_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CHR_W-1:0]  chr_even;

    assign accept  = start && !busy;
    assign region  = t_region'(r_addr[15:13]);
    assign is_ram  = (region == RG_RAM);
    assign is_wr   = (r_op == OP_CPU_WR);
    assign prg_data_wr = is_wr && (region == RG_BANK) && r_addr[0]
                       && (r_target == TGT_PRG_A || r_target == TGT_PRG_B);
    assign cfg_eff  = eff_count(i_cfg_wdata);
    assign cnt_eff  = eff_count(r_cnt);
    assign chr_even = {r_wdata[7:1], 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = prg_data_wr ? ST_MOD : ST_IDLE;
            ST_MOD:  if (mod_rsp.done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy    = (r_state != ST_IDLE);
        exec_en = (r_state == ST_EXEC);
        mod_go  = exec_en && prg_data_wr;
        mod_fin = (r_state == ST_MOD) && mod_rsp.done;
    end

    assign mod_req.go       = mod_go;
    assign mod_req.dividend = r_wdata[BANK_W-1:0];
    assign mod_req.divisor  = cnt_eff;

    bmsi_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // read results
    always_comb begin
        x_off = '0;
        x_rd  = '0;
        x_hit = 1'b0;
        unique case (r_op)
            OP_CPU_RD: begin
                if (is_ram) begin
                    x_rd  = r_ram_q;
                    x_hit = 1'b1;
                end else if (r_addr[15]) begin
                    x_off = {r_prg[r_addr[14:13]], r_addr[SLOT_AW-1:0]};
                end
            end
            OP_PPU_RD: begin
                if (r_nt) begin
                    if (r_mirror_h) x_off = {8'd0, r_addr[11], r_addr[9:0]};
                    else            x_off = {8'd0, r_addr[10:0]};
                end else begin
                    x_off = {1'b0, r_chr[r_addr[12:10]], r_addr[9:0]};
                end
            end
            default: ;
        endcase
    end

    // interrupt counter
    always_comb begin
        n_irq_count   = r_irq_count;
        n_irq_level   = r_irq_level;
        n_irq_guard   = r_irq_guard;
        n_reload_pend = r_reload_pend;
        n_irq_enabled = r_irq_enabled;
        if (r_op == OP_TICK) begin
            priority if (r_reload_pend) begin
                n_irq_count   = r_irq_reload;
                n_reload_pend = 1'b0;
                n_irq_level   = (r_irq_reload == 8'd0) && r_irq_enabled;
            end else if (r_irq_count == 8'd0) begin
                n_irq_count = r_irq_reload;
                n_irq_level = r_irq_enabled && !r_irq_guard;
                n_irq_guard = r_irq_enabled && !r_irq_guard;
            end else begin
                n_irq_count = r_irq_count - 8'd1;
                if (r_irq_count == 8'd1) n_irq_level = r_irq_enabled;
            end
        end else if (is_wr && region == RG_IRQ_LOAD && r_addr[0]) begin
            n_reload_pend = 1'b1;
            n_irq_count   = 8'd0;
        end else if (is_wr && region == RG_IRQ_EN) begin
            n_irq_enabled = r_addr[0];
            if (!r_addr[0]) n_irq_level = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_op'(i_op);
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_nt    <= i_nametable_fetch;
        end
    end

    // work RAM
    always_ff @(posedge i_clk) begin
        if (exec_en && is_wr && is_ram) r_ram[r_addr[RAM_AW-1:0]] <= r_wdata;
        if (accept) r_ram_q <= r_ram[i_address[RAM_AW-1:0]];
    end

    // mapper registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= CNT_RESET;
            r_prg[0]      <= '0;
            r_prg[1]      <= BANK_W'(1);
            r_prg[2]      <= BANK_W'(CNT_RESET - 7'd2);
            r_prg[3]      <= BANK_W'(CNT_RESET - 7'd1);
            for (int i = 0; i < 8; i++) r_chr[i] <= '0;
            r_target      <= '0;
            r_prg_swap    <= 1'b0;
            r_chr_inv     <= 1'b0;
            r_mirror_h    <= 1'b0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_reload_pend <= 1'b0;
            r_irq_enabled <= 1'b0;
            r_irq_level   <= 1'b0;
            r_irq_guard   <= 1'b0;
            r_mod_slot    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cnt    <= i_cfg_wdata;
                r_prg[0] <= '0;
                r_prg[1] <= BANK_W'(1);
                r_prg[2] <= BANK_W'(cfg_eff - 7'd2);
                r_prg[3] <= BANK_W'(cfg_eff - 7'd1);
            end
            if (exec_en) begin
                r_irq_count   <= n_irq_count;
                r_irq_level   <= n_irq_level;
                r_irq_guard   <= n_irq_guard;
                r_reload_pend <= n_reload_pend;
                r_irq_enabled <= n_irq_enabled;
                if (is_wr) begin
                    unique case (region)
                        RG_BANK: begin
                            if (!r_addr[0]) begin
                                r_target   <= r_wdata[2:0];
                                r_prg_swap <= r_wdata[6];
                                r_chr_inv  <= r_wdata[7];
                                if (r_wdata[6] != r_prg_swap) begin
                                    r_prg[0] <= r_prg[2];
                                    r_prg[2] <= r_prg[0];
                                end
                                if (r_wdata[7] != r_chr_inv) begin
                                    for (int i = 0; i < 4; i++) begin
                                        r_chr[i]   <= r_chr[i+4];
                                        r_chr[i+4] <= r_chr[i];
                                    end
                                end
                            end else begin
                                priority if (r_target == TGT_PRG_A) begin
                                    r_mod_slot <= r_prg_swap ? 2'd2 : 2'd0;
                                end else if (r_target == TGT_PRG_B) begin
                                    r_mod_slot <= 2'd1;
                                end else if (!r_target[2] && !r_target[1]) begin
                                    r_chr[{r_chr_inv, r_target[0], 1'b0}] <= chr_even;
                                    r_chr[{r_chr_inv, r_target[0], 1'b1}] <=
                                        chr_even + 8'd1;
                                end else begin
                                    r_chr[{~r_chr_inv, 2'(r_target - 3'd2)}] <= r_wdata;
                                end
                            end
                        end
                        RG_MIRROR:   if (!r_addr[0]) r_mirror_h <= r_wdata[0];
                        RG_IRQ_LOAD: if (!r_addr[0]) r_irq_reload <= r_wdata;
                        default: ;
                    endcase
                end
            end
            if (mod_fin) r_prg[r_mod_slot] <= mod_rsp.remainder;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (exec_en && !prg_data_wr) || mod_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_out_off <= x_off;
            r_out_rd  <= x_rd;
            r_out_hit <= x_hit;
            r_out_irq <= n_irq_level;
        end
    end

    assign o_done          = r_done;
    assign o_mapped_offset = r_out_off;
    assign o_read_data     = r_out_rd;
    assign o_ram_hit       = r_out_hit;
    assign o_irq_out       = r_out_irq;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_EXEC || r_state == ST_MOD))
        else $error("result strobe without execute");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_EXEC)
        else $error("accepted word not executed");

    a_irq_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq_level |-> r_irq_enabled)
        else $error("irq raised while disabled");

    a_hit_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out_hit) |-> (r_out_off == '0))
        else $error("ram hit with nonzero offset");

endmodule
